[sv/pls_pkg.sv]
// Shared types and constants for the point to line distance pipeline.
// No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

    localparam int DIST_BITS = 21;  // result width
    localparam int OUT_FRAC  = 8;   // result fractional bits

    // control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic degen;
        logic dzero;   // denominator zero: result forced to zero
    } ctl_t;

endpackage

[sv/point_line_distance.sv]
// Top level of the point to line distance pipeline.
// Depends on pls_pkg and pls_root_step.
`timescale 1ns / 1ps

// Fully pipelined: one query word is taken in every cycle (busy is always low)
// and its result appears on done/distance/degenerate from the output register.
// Five stages form the differences, products, numerator, denominator
// and the square of the numerator; 21 stages each settle one result bit of
// floor(|N| * 2^(8-FRAC_BITS) / sqrt(A^2 + B^2)) by add and compare; one
// output register follows. The receiver cannot stall the block.

module point_line_distance #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] line_first_x,
    input  logic signed [COORD_WIDTH-1:0] line_first_y,
    input  logic signed [COORD_WIDTH-1:0] line_second_x,
    input  logic signed [COORD_WIDTH-1:0] line_second_y,
    output logic                          done,
    output logic [pls_pkg::DIST_BITS-1:0] distance,
    output logic                          degenerate
);

    localparam int DB   = pls_pkg::DIST_BITS;
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int SH   = pls_pkg::OUT_FRAC - FRAC_BITS;
    localparam int NUMW = PW + SH;
    localparam int DENW = PW;
    localparam int H    = (NUMW + 1) / 2;
    localparam int HI   = NUMW - H;
    localparam int SQW  = 2 * NUMW;
    localparam int TWA  = 2 * DB + DENW + 1;
    localparam int TW   = (TWA > SQW) ? TWA : SQW;
    localparam int DQW  = DB + DENW;
    localparam int LAT  = DB + 6;

    // stage 1: differences
    pls_pkg::ctl_t          c1_reg;
    logic signed [DW-1:0]   dx_reg, dy_reg, a_reg, b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_reg <= '0;
        else
        begin
            c1_reg.valid <= start;
            c1_reg.degen <= (line_first_x == line_second_x) &&
                            (line_first_y == line_second_y);
            c1_reg.dzero <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= DW'(point_x) - DW'(line_first_x);
        dy_reg <= DW'(point_y) - DW'(line_first_y);
        a_reg  <= DW'(line_second_y) - DW'(line_first_y);
        b_reg  <= DW'(line_first_x) - DW'(line_second_x);
    end

    // stage 2: products; degenerate case reuses the cross multipliers for squares
    pls_pkg::ctl_t          c2_reg;
    logic signed [PW-1:0]   m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DW-1:0]   op1, op2;

    assign op1 = c1_reg.degen ? dx_reg : a_reg;
    assign op2 = c1_reg.degen ? dy_reg : b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_reg <= '0;
        else
            c2_reg <= c1_reg;
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= PW'(op1) * PW'(dx_reg);
        m2_reg <= PW'(op2) * PW'(dy_reg);
        m3_reg <= PW'(a_reg) * PW'(a_reg);
        m4_reg <= PW'(b_reg) * PW'(b_reg);
    end

    // stage 3: numerator magnitude and denominator
    pls_pkg::ctl_t          c3_reg, c3_next;
    logic [NUMW-1:0]        num_reg;
    logic [DENW-1:0]        den3_reg;
    logic signed [NW-1:0]   sum_s, abs_s;
    logic [DENW-1:0]        sq_sum, den_next;
    logic [PW-1:0]          mag;

    always_comb
    begin
        sum_s    = NW'(m1_reg) + NW'(m2_reg);
        abs_s    = (sum_s < 0) ? -sum_s : sum_s;
        sq_sum   = DENW'(m3_reg) + DENW'(m4_reg);
        mag      = c2_reg.degen ? PW'(sum_s) : abs_s[PW-1:0];
        den_next = c2_reg.degen ? PW'(sum_s) : sq_sum;
        c3_next       = c2_reg;
        c3_next.dzero = (den_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_reg <= '0;
        else
            c3_reg <= c3_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= NUMW'(mag) << SH;
        den3_reg <= den_next;
    end

    // stage 4: partial squares of the numerator
    pls_pkg::ctl_t          c4_reg;
    logic [2*HI-1:0]        hh_reg;
    logic [HI+H-1:0]        hl_reg;
    logic [2*H-1:0]         ll_reg;
    logic [DENW-1:0]        den4_reg;
    logic [HI-1:0]          n_hi;
    logic [H-1:0]           n_lo;

    assign n_hi = num_reg[NUMW-1:H];
    assign n_lo = num_reg[H-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c4_reg <= '0;
        else
            c4_reg <= c3_reg;
    end

    always_ff @(posedge clk)
    begin
        hh_reg   <= (2*HI)'(n_hi) * (2*HI)'(n_hi);
        hl_reg   <= (HI+H)'(n_hi) * (HI+H)'(n_lo);
        ll_reg   <= (2*H)'(n_lo) * (2*H)'(n_lo);
        den4_reg <= den3_reg;
    end

    // stage 5: num^2, start of the root chain
    pls_pkg::ctl_t          ctl_c [0:DB];
    logic [TW-1:0]          rem_c [0:DB];
    logic [DQW-1:0]         dq_c  [0:DB];
    logic [DB-1:0]          q_c   [0:DB];
    logic [DENW-1:0]        den_c [0:DB];
    pls_pkg::ctl_t          c5_reg;
    logic [TW-1:0]          rem5_reg;
    logic [DENW-1:0]        den5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c5_reg <= '0;
        else
            c5_reg <= c4_reg;
    end

    always_ff @(posedge clk)
    begin
        rem5_reg <= (TW'(hh_reg) << (2 * H)) + (TW'(hl_reg) << (H + 1)) + TW'(ll_reg);
        den5_reg <= den4_reg;
    end

    assign ctl_c[0] = c5_reg;
    assign rem_c[0] = rem5_reg;
    assign dq_c[0]  = '0;
    assign q_c[0]   = '0;
    assign den_c[0] = den5_reg;

    for (genvar k = 0; k < DB; k++)
    begin : g_root
        pls_root_step #(
            .BIT  (DB - 1 - k),
            .TW   (TW),
            .DENW (DENW)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_c[k]),
            .rem_in  (rem_c[k]),
            .dq_in   (dq_c[k]),
            .q_in    (q_c[k]),
            .den_in  (den_c[k]),
            .ctl_out (ctl_c[k+1]),
            .rem_out (rem_c[k+1]),
            .dq_out  (dq_c[k+1]),
            .q_out   (q_c[k+1]),
            .den_out (den_c[k+1])
        );
    end

    // output word
    logic           done_reg;
    logic [DB-1:0]  dist_reg;
    logic           degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_c[DB].valid;
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= ctl_c[DB].dzero ? '0 : q_c[DB];
        degen_reg <= ctl_c[DB].degen;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign distance   = dist_reg;
    assign degenerate = degen_reg;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("accepted word did not complete on time");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching word");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline refused a word");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_c[DB].valid && ctl_c[DB].dzero |-> ctl_c[DB].degen)
        else $error("zero denominator on a proper line");

endmodule

[sv/pls_root_step.sv]
// One bit of the restoring ratio square root: tries q | 2^BIT against num^2.
// Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_root_step #(
    parameter int BIT  = 0,
    parameter int TW   = 77,
    parameter int DENW = 34
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pls_pkg::ctl_t                  ctl_in,
    input  logic [TW-1:0]                  rem_in,
    input  logic [pls_pkg::DIST_BITS+DENW-1:0] dq_in,
    input  logic [pls_pkg::DIST_BITS-1:0]  q_in,
    input  logic [DENW-1:0]                den_in,
    output pls_pkg::ctl_t                  ctl_out,
    output logic [TW-1:0]                  rem_out,
    output logic [pls_pkg::DIST_BITS+DENW-1:0] dq_out,
    output logic [pls_pkg::DIST_BITS-1:0]  q_out,
    output logic [DENW-1:0]                den_out
);

    localparam int DQW = pls_pkg::DIST_BITS + DENW;

    pls_pkg::ctl_t             ctl_reg;
    logic [TW-1:0]             rem_reg, rem_next;
    logic [DQW-1:0]            dq_reg, dq_next;
    logic [pls_pkg::DIST_BITS-1:0] q_reg, q_next;
    logic [DENW-1:0]           den_reg;
    logic [TW-1:0]             trial;

    // (q + 2^b)^2 * den - q^2 * den = 2^(b+1) * q*den + 2^(2b) * den
    always_comb
    begin
        trial    = (TW'(dq_in) << (BIT + 1)) + (TW'(den_in) << (2 * BIT));
        rem_next = rem_in;
        dq_next  = dq_in;
        q_next   = q_in;
        if (trial <= rem_in)
        begin
            rem_next    = rem_in - trial;
            dq_next     = dq_in + (DQW'(den_in) << BIT);
            q_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        q_reg   <= q_next;
        den_reg <= den_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;

endmodule

[test/pld_checker.sv]
// Checker for point_line_distance: snoops accepted query words, predicts the distance
// and degenerate flag, and compares them with each done strobe. Depends on pls_pkg.
`timescale 1ns / 1ps

module pld_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [15:0]                    point_x,
    input  logic signed [15:0]                    point_y,
    input  logic signed [15:0]                    line_first_x,
    input  logic signed [15:0]                    line_first_y,
    input  logic signed [15:0]                    line_second_x,
    input  logic signed [15:0]                    line_second_y,
    input  logic                                  done,
    input  logic [pls_pkg::DIST_BITS-1:0]         distance,
    input  logic                                  degenerate,
    output int                                    errors,
    output int                                    pending
);

    typedef struct {
        logic [pls_pkg::DIST_BITS-1:0] dist_val;
        logic                          degen;
    } dist_word_t;

    dist_word_t expected_q[$];

    // largest q with q*q*den <= num*num, settled one bit at a time
    function automatic logic [pls_pkg::DIST_BITS-1:0] isqrt_ratio(logic [127:0] num,
                                                                 logic [127:0] den);
        logic [pls_pkg::DIST_BITS-1:0] q;
        logic [pls_pkg::DIST_BITS-1:0] t;
        logic [127:0] nn;
        q = '0;
        if (den == 0)
            return '0;
        nn = num * num;
        for (int b = pls_pkg::DIST_BITS - 1; b >= 0; b--)
        begin
            t = q | pls_pkg::DIST_BITS'(1 << b);
            if ({107'd0, t} * {107'd0, t} * den <= nn)
                q = t;
        end
        return q;
    endfunction

    function automatic dist_word_t predict_distance(
        logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] x1,
        logic signed [15:0] y1, logic signed [15:0] x2, logic signed [15:0] y2);
        dist_word_t w;
        longint dx, dy, a, bb, n;
        logic [127:0] num, den;
        dx = longint'(px) - longint'(x1);
        dy = longint'(py) - longint'(y1);
        w.degen = (x1 == x2) && (y1 == y2);
        if (w.degen)
        begin
            den = 128'(dx * dx + dy * dy);
            num = den;
        end
        else
        begin
            a = longint'(y2) - longint'(y1);
            bb = longint'(x1) - longint'(x2);
            n = a * dx + bb * dy;
            num = 128'(n < 0 ? -n : n);
            den = 128'(a * a + bb * bb);
        end
        num = num << (pls_pkg::OUT_FRAC - 4);
        w.dist_val = isqrt_ratio(num, den);
        return w;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        dist_word_t e;
        if (!rst_n)
        begin
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word dist=%0d degen=%0d", $time, distance,
                             degenerate);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.dist_val !== distance || e.degen !== degenerate)
                    begin
                        $display({"%0t: mismatch expected dist=%0d degen=%0d, ",
                                  "actual dist=%0d degen=%0d"},
                                 $time, e.dist_val, e.degen, distance, degenerate);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(predict_distance(point_x, point_y, line_first_x,
                                                      line_first_y, line_second_x, line_second_y));
        end
    end
endmodule

[test/tb_top.sv]
// Stimulus and verdict for point_line_distance; directed corners then random queries.
// Depends on pls_pkg, point_line_distance and pld_checker.
`timescale 1ns / 1ps

module tb_top;
    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [15:0] px = 0, py = 0, x1 = 0, y1 = 0, x2 = 0, y2 = 0;
    logic done;
    logic [pls_pkg::DIST_BITS-1:0] distance;
    logic degenerate;
    int errors, pending;
    int idle_pct;

    always #2 clk = ~clk;

    point_line_distance dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(px), .point_y(py), .line_first_x(x1), .line_first_y(y1),
        .line_second_x(x2), .line_second_y(y2),
        .done(done), .distance(distance), .degenerate(degenerate)
    );

    pld_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(px), .point_y(py), .line_first_x(x1), .line_first_y(y1),
        .line_second_x(x2), .line_second_y(y2),
        .done(done), .distance(distance), .degenerate(degenerate),
        .errors(errors), .pending(pending)
    );

    // present one word, hold it until taken; start stays high if next word follows
    task automatic send_query(input logic [15:0] a, b, c, d, e, f);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        px <= a; py <= b; x1 <= c; y1 <= d; x2 <= e; y2 <= f;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom_range(15)) - 16'd8;
            1: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [15:0] c1, c2, c3, c4;
        int waited;
        idle_pct = 10;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed corners
        send_query(0, 0, 0, 0, 0, 0);                          // all coincide
        send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        send_query(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_query(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
        send_query(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        send_query(16, 16, 0, 0, 32, 32);                      // point on the line
        send_query(5, 7, 5, 7, 5, 7);                          // point on coincident points
        send_query(16'hffff, 16'hffff, 0, 0, 1, 0);
        send_query(3, 16'hfff0, 1, 1, 1, 2);
        send_query(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0);
        for (int k = 0; k < 1000; k++)
        begin
            if (k == 333) idle_pct = 52;
            if (k == 666) idle_pct = 0;
            c1 = rand_coord(); c2 = rand_coord(); c3 = rand_coord(); c4 = rand_coord();
            case ($urandom_range(9))
                0: send_query(rand_coord(), rand_coord(), c1, c2, c1, c2);
                1: send_query(c1, c2, c1, c2, c1, c2);
                2: send_query(c1 + ((c3 - c1) << 1), c2 + ((c4 - c2) << 1), c1, c2, c3, c4);
                default: send_query(rand_coord(), rand_coord(), c1, c2, c3, c4);
            endcase
        end
        start <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[filelist.f]
sv/pls_pkg.sv
sv/pls_root_step.sv
sv/point_line_distance.sv
test/pld_checker.sv
test/tb_top.sv
